/* hdl/stsg_pkg.sv */
// Package with the shared widths, data types and CORDIC constants of the sine sample generator.
package stsg_pkg;

    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int AMP_W       = 12;
    localparam int PHASE_W     = 16;
    localparam int QUO_W       = 32;
    localparam int DIV_STEPS   = IDX_W + QUO_W;
    localparam int XY_W        = 34;
    localparam int Z_W         = 33;
    localparam int CORDIC_STEPS = 24;
    localparam int SINE_W      = 16;
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_CODE_BITS  = 12;

    localparam logic [CNT_W-1:0]   RESET_POINT_COUNT = 11'd100;
    localparam logic [AMP_W-1:0]   RESET_AMPLITUDE   = 12'd2047;
    localparam logic [PHASE_W-1:0] RESET_PHASE       = 16'd0;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        REG_POINT_COUNT  = 2'd0,
        REG_AMPLITUDE    = 2'd1,
        REG_PHASE_OFFSET = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [IDX_W-1:0] idx;
        logic [QUO_W-1:0] quo;
    } div_data_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_data_t;

    function automatic logic signed [Z_W-1:0] atan_turn(input int step);
        logic signed [Z_W-1:0] a;
        case (step)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41722;
            15: a = 33'sd20861;
            16: a = 33'sd10430;
            17: a = 33'sd5215;
            18: a = 33'sd2608;
            19: a = 33'sd1304;
            20: a = 33'sd652;
            21: a = 33'sd326;
            22: a = 33'sd163;
            23: a = 33'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/stsg_div_cell.sv */
// One restoring division step that turns the point index into a turn fraction.
module stsg_div_cell
    import stsg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  div_data_t        in_data,
    input  logic [CNT_W-1:0] divisor,
    output logic             out_valid,
    output div_data_t        out_data
);

    logic        valid_reg;
    div_data_t   data_reg;
    div_data_t   data_next;
    logic [CNT_W:0] rem2;
    logic        ge;

    always_comb begin
        rem2 = {in_data.rem, in_data.idx[IDX_W-1]};
        ge   = (rem2 >= {1'b0, divisor});
        data_next.rem = ge ? CNT_W'(rem2 - {1'b0, divisor}) : rem2[CNT_W-1:0];
        data_next.idx = {in_data.idx[IDX_W-2:0], 1'b0};
        data_next.quo = {in_data.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/stsg_cordic_cell.sv */
// One rotation step of the sine CORDIC.
module stsg_cordic_cell
    import stsg_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  cordic_data_t in_data,
    output logic         out_valid,
    output cordic_data_t out_data
);

    localparam logic signed [Z_W-1:0] ATAN = atan_turn(STEP);

    logic         valid_reg;
    cordic_data_t data_reg;
    cordic_data_t data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb begin
        dx = in_data.y >>> STEP;
        dy = in_data.x >>> STEP;
        if (!in_data.z[Z_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/sine_table_sample_generator.sv */
// Top level of the sine table sample generator: divider chain, CORDIC chain and DAC scaling.
// The block takes one point index per clock while the output is not stalled and returns its DAC code:
// 42 division cells form the turn fraction, one cell adds the phase and folds the angle,
// 24 CORDIC cells give the sine, and three stages round, scale by the amplitude and
// saturate. The whole chain advances whenever the output register is empty or taken, so
// a stall on the result side holds every item in place. Configuration must be stable while
// items are in flight.
module sine_table_sample_generator
    import stsg_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int CODE_BITS  = DEF_CODE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [PHASE_W-1:0]   cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_point_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CODE_BITS-1:0] m_dac_code,
    output logic                 m_clipped
);

    localparam logic [CODE_BITS-1:0] FULL_CODE = {CODE_BITS{1'b1}};
    localparam logic signed [32:0]   OFFSET    = 33'sd32768 * ((33'sd1 <<< CODE_BITS) - 33'sd1);

    logic [CNT_W-1:0]   point_count_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [CNT_W-1:0]   divisor;
    logic               en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= RESET_POINT_COUNT;
            amplitude_reg   <= RESET_AMPLITUDE;
            phase_reg       <= RESET_PHASE;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_POINT_COUNT:  point_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_AMPLITUDE:    amplitude_reg   <= cfg_wdata[AMP_W-1:0];
                REG_PHASE_OFFSET: phase_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (point_count_reg == '0) begin
            divisor = CNT_W'(1);
        end else if (32'(point_count_reg) > 32'(MAX_POINTS)) begin
            divisor = CNT_W'(MAX_POINTS);
        end else begin
            divisor = point_count_reg;
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic      div_valid [0:DIV_STEPS];
    div_data_t div_data  [0:DIV_STEPS];

    assign div_valid[0]     = s_valid;
    assign div_data[0].rem  = '0;
    assign div_data[0].idx  = s_point_index;
    assign div_data[0].quo  = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        stsg_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .divisor   (divisor),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    logic         cor_valid [0:CORDIC_STEPS];
    cordic_data_t cor_data  [0:CORDIC_STEPS];
    logic         fold_valid_reg;
    cordic_data_t fold_reg;
    logic [31:0]  angle;
    logic [31:0]  turn;

    always_comb begin
        angle = div_data[DIV_STEPS].quo + {phase_reg, 16'd0};
        if (angle[31] != angle[30]) begin
            turn = 32'h8000_0000 - angle;
        end else begin
            turn = angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (en) begin
            fold_valid_reg <= div_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg.x <= CORDIC_GAIN;
            fold_reg.y <= '0;
            fold_reg.z <= signed'({turn[31], turn});
        end
    end

    assign cor_valid[0] = fold_valid_reg;
    assign cor_data[0]  = fold_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        stsg_cordic_cell #(.STEP(k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cor_valid[k]),
            .in_data   (cor_data[k]),
            .out_valid (cor_valid[k+1]),
            .out_data  (cor_data[k+1])
        );
    end

    logic                     sine_valid_reg;
    logic signed [SINE_W-1:0] sine_reg;
    logic signed [XY_W-1:0]   rounded;
    logic signed [XY_W-1:0]   sine_next;

    always_comb begin
        rounded = (cor_data[CORDIC_STEPS].y + XY_W'(16384)) >>> 15;
        if (rounded > XY_W'(32767)) begin
            sine_next = XY_W'(32767);
        end else if (rounded < -XY_W'(32767)) begin
            sine_next = -XY_W'(32767);
        end else begin
            sine_next = rounded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sine_valid_reg <= 1'b0;
        end else if (en) begin
            sine_valid_reg <= cor_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= sine_next[SINE_W-1:0];
        end
    end

    logic               prod_valid_reg;
    logic signed [28:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= sine_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 29'(sine_reg * signed'({1'b0, amplitude_reg}));
        end
    end

    logic signed [32:0]   num;
    logic [16:0]          code_raw;
    logic [CODE_BITS-1:0] code_next;
    logic                 clip_next;
    logic                 out_valid_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic                 clip_reg;

    always_comb begin
        num      = 33'(prod_reg) * 33'sd2 + OFFSET;
        code_raw = num[32:16];
        if (num < 0) begin
            code_next = '0;
            clip_next = 1'b1;
        end else if (code_raw > 17'(FULL_CODE)) begin
            code_next = FULL_CODE;
            clip_next = 1'b1;
        end else begin
            code_next = code_raw[CODE_BITS-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            code_reg <= code_next;
            clip_reg <= clip_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_dac_code = code_reg;
    assign m_clipped  = clip_reg;

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow the output register");

    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> (m_dac_code == '0) || (m_dac_code == FULL_CODE))
        else $error("clipped item is not at a rail");

    a_accept_enters_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> div_valid[1])
        else $error("accepted item did not enter the divider chain");

    a_stall_holds_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(prod_valid_reg) && $stable(fold_valid_reg))
        else $error("chain moved during an output stall");

endmodule
